// ===== hdl/rclc_pkg.sv =====
// shared constants and types of the rom container length checker
package rclc_pkg;

  // default width of the byte counter
  localparam int RCLC_COUNT_BITS = 32;

  // verdict codes
  localparam logic [2:0] ST_VALID    = 3'd0;
  localparam logic [2:0] ST_BAD_SIG  = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_RESERVED = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // container signature, 00 'E' 'R' 'M'
  localparam logic [7:0] SIG_BYTES [4] = '{8'h00, 8'h45, 8'h52, 8'h4D};

  // lead byte classes, top two bits
  localparam logic [1:0] LEAD_ID1     = 2'b00;
  localparam logic [1:0] LEAD_ID2     = 2'b01;
  localparam logic [1:0] LEAD_LENGTH  = 2'b10;
  localparam logic [1:0] LEAD_RESERVE = 2'b11;

  // one verdict from the parser
  typedef struct packed {
    logic       valid;
    logic [2:0] status;
    logic [31:0] length;
  } rclc_res_t;

endpackage

// ===== hdl/rclc_parser.sv =====
// parse state and per-byte next-state and verdict logic
module rclc_parser import rclc_pkg::*; #(
  parameter int COUNT_BITS = RCLC_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  output rclc_res_t  res
);

  localparam int CNT_W = (COUNT_BITS < 32) ? COUNT_BITS : 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEAD,
    PH_LEN1,
    PH_LEN2,
    PH_SKIP
  } phase_t;

  phase_t           phase_r, phase_nxt, phase_e;
  logic [1:0]       sig_idx_r, sig_idx_nxt, sig_idx_e;
  logic [22:0]      remain_r, remain_nxt, remain_e;
  logic [13:0]      len_hi_r, len_hi_nxt, len_hi_e;
  logic [CNT_W-1:0] count_r, count_nxt, count_e;
  logic             done_r, done_nxt, done_e;
  logic [22:0]      remain_dec;

  // start of a new buffer restarts the parse before the byte is taken
  always_comb begin
    if (first_byte) begin
      phase_e   = PH_SIG;
      sig_idx_e = '0;
      remain_e  = '0;
      len_hi_e  = '0;
      count_e   = '0;
      done_e    = 1'b0;
    end else begin
      phase_e   = phase_r;
      sig_idx_e = sig_idx_r;
      remain_e  = remain_r;
      len_hi_e  = len_hi_r;
      count_e   = count_r;
      done_e    = done_r;
    end
  end

  assign remain_dec = (remain_e != '0) ? remain_e - 23'd1 : remain_e;

  // next state and verdict for one byte
  always_comb begin
    phase_nxt   = phase_e;
    sig_idx_nxt = sig_idx_e;
    remain_nxt  = remain_e;
    len_hi_nxt  = len_hi_e;
    count_nxt   = count_e;
    done_nxt    = done_e;
    res         = '0;
    if (!done_e) begin
      if (count_e == CNT_MAX) begin
        res.valid  = 1'b1;
        res.status = ST_OVERFLOW;
      end else begin
        count_nxt = count_e + 1'b1;
        unique case (phase_e)
          PH_SIG: begin
            if (data_byte != SIG_BYTES[sig_idx_e]) begin
              res.valid  = 1'b1;
              res.status = ST_BAD_SIG;
            end else if (sig_idx_e == 2'd3) begin
              phase_nxt = PH_LEAD;
            end else begin
              sig_idx_nxt = sig_idx_e + 2'd1;
            end
          end
          PH_LEN1: begin
            len_hi_nxt = {len_hi_e[5:0], data_byte};
            phase_nxt  = PH_LEN2;
          end
          PH_LEN2: begin
            remain_nxt = {1'b0, len_hi_e, data_byte} + 23'd1;
            phase_nxt  = PH_SKIP;
          end
          PH_SKIP: begin
            remain_nxt = remain_dec;
            if (remain_dec == '0) phase_nxt = PH_LEAD;
          end
          PH_LEAD: begin
            if (data_byte == 8'h00) begin
              res.valid  = 1'b1;
              res.status = ST_VALID;
              res.length = 32'(count_nxt);
            end else begin
              unique case (data_byte[7:6])
                LEAD_ID1: ;
                LEAD_ID2: begin
                  remain_nxt = 23'd1;
                  phase_nxt  = PH_SKIP;
                end
                LEAD_LENGTH: begin
                  len_hi_nxt = {8'h00, data_byte[5:0]};
                  phase_nxt  = PH_LEN1;
                end
                LEAD_RESERVE: begin
                  res.valid  = 1'b1;
                  res.status = ST_RESERVED;
                end
                default: ;
              endcase
            end
          end
          default: ;
        endcase
        // buffer ended before any verdict
        if (last_byte && !res.valid) begin
          res.valid  = 1'b1;
          res.status = ST_TRUNC;
        end
      end
      if (res.valid) done_nxt = 1'b1;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SIG;
      sig_idx_r <= '0;
      remain_r  <= '0;
      len_hi_r  <= '0;
      count_r   <= '0;
      done_r    <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      sig_idx_r <= sig_idx_nxt;
      remain_r  <= remain_nxt;
      len_hi_r  <= len_hi_nxt;
      count_r   <= count_nxt;
      done_r    <= done_nxt;
    end
  end

endmodule

// ===== hdl/rom_container_length_checker_unit.sv =====
// top level: input register, parser and verdict register
// Checks a resource container that arrives one byte per item and gives one
// verdict per buffer: valid with the length up to and including the
// terminator, or bad signature, truncated, reserved lead or length overflow.
// One item is taken per clock while no stalled verdict waits; a byte moves from
// the input register through the parser into the verdict register, which
// drives the result ports. The per-byte path is the parser's next-state logic:
// phase, signature index, length fields and the byte counter increment.
// A stall on the result side holds the input register, and the input stalls
// only while a verdict waits. After the verdict of a buffer, further bytes are
// dropped until first_byte.
module rom_container_length_checker_unit import rclc_pkg::*; #(
  parameter int COUNT_BITS = RCLC_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_rom_length
);

  logic        in_valid_r;
  logic [7:0]  in_data_r;
  logic        in_first_r;
  logic        in_last_r;
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_length_r;
  logic        fire;
  rclc_res_t   res;

  // the held byte goes through once the verdict register can take a result
  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r  <= in_data_byte;
      in_first_r <= in_first_byte;
      in_last_r  <= in_last_byte;
    end
  end

  rclc_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .data_byte (in_data_r),
    .first_byte(in_first_r),
    .last_byte (in_last_r),
    .res       (res)
  );

  // verdict register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_status_r <= res.status;
      out_length_r <= res.length;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_rom_length = out_length_r;

endmodule

// ===== hdl/rclc_checker.sv =====
// port-level checker of the rom container length checker and its bind
module rclc_checker import rclc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_rom_length
);

  // a stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_rom_length))
    else $error("stalled verdict changed");

  // only a valid verdict carries a length
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_VALID) |-> out_rom_length == 32'd0)
    else $error("length on a failed verdict");

  // a valid container holds at least the signature and the terminator
  a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_VALID) |-> out_rom_length >= 32'd5)
    else $error("valid verdict too short");

  // status code is one of the defined verdicts
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_OVERFLOW)
    else $error("undefined status code");

endmodule

bind rom_container_length_checker_unit rclc_checker u_rclc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_rom_length(out_rom_length)
);
